### rtl/core/pulse_period_speed_meter_assert.svh
// assertion macros for the pulse period speed meter checker
// expects aclk and aresetn in the scope where the macros are used
`ifndef PULSE_PERIOD_SPEED_METER_ASSERT_SVH
`define PULSE_PERIOD_SPEED_METER_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pps_pkg.sv
// shared types and constants of the pulse period speed meter
// no dependencies
`default_nettype none

package pps_pkg;

    localparam int GAP_W   = 27;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 24;
    localparam int CORR_W  = 9;
    localparam int CFG_A_W = 2;

    // gap window depth, a power of two so the mean is a shift
    localparam int WINDOW_DEPTH = 16;

    localparam logic [GAP_W-1:0] STOP_MARKER = 27'h7FF_FFFF;

    localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd5000000;
    localparam logic [SPEED_W-1:0] NUMER_RESET   = 24'd10000000;
    localparam logic [CORR_W-1:0]  CORR_RESET    = 9'd9;

    localparam logic [CFG_A_W-1:0] REG_STOP_TIMEOUT = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_SPEED_NUMER  = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_LENGTH_CORR  = 2'd2;

    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_UPD  = 5'b00010,
        ST_DIVM = 5'b00100,
        ST_DIVS = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage

`default_nettype wire

### rtl/core/pps_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// standalone, no package dependencies
`default_nettype none

module pps_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 27
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic           fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = ~diff[DEN_W];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

### rtl/core/pulse_period_speed_meter.sv
// Pulse period speed meter. Each input word is a sensor pulse (tuser 0) or a stop poll
// (tuser 1) with a 32-bit microsecond timestamp. The last WINDOW_DEPTH gaps (a stop poll
// enters the stop marker) sit in an on-chip memory read in the cycle before the update; a
// running sum gives the mean gap by a shift, and the speed is the programmed numerator over
// that mean. A word that changes the state passes through the update, the start of the
// bit-serial divider of the numerator by the mean, the divide wait and the emit state
// before the next word is taken; when the mean gap is the stop marker or zero the divider
// is skipped. A word that changes nothing (repeated timestamp, poll while stopped or within
// the timeout) is taken in idle and gives no result. The result sits in an output register,
// so the next word is taken while it waits; a following result that finds it still full
// holds the input off until it drains. Depends on pps_pkg and pps_div.
`default_nettype none

module pulse_period_speed_meter
    import pps_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [31:0]        cfg_wdata,
    // input words
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,   // time_us
    input  wire logic               s_tuser,   // operation
    // result words
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [55:0]             m_tdata,   // speed_value, length_value
    output logic                    m_tuser    // is_moving
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = GAP_W + PTR_W;
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(WINDOW_DEPTH) * SUM_W'(STOP_MARKER);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);

    state_t state_reg, state_next;

    logic [TIME_W-1:0]       timeout_reg, timeout_next;
    logic [SPEED_W-1:0]      numer_reg, numer_next;
    logic [CORR_W-1:0]       corr_reg, corr_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [PTR_W-1:0]        pos_reg, pos_next;
    logic [TIME_W-1:0]       last_time_reg, last_time_next;
    logic [31:0]             tick_reg, tick_next;
    logic                    moving_reg, moving_next;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic [GAP_W-1:0]        rd_data_reg;
    logic [GAP_W-1:0]        gap_reg, gap_next;
    logic [31:0]             prod_reg, prod_next;
    logic [31:0]             len_reg, len_next;
    logic [SPEED_W-1:0]      speed_reg, speed_next;
    logic                    res_moving_reg, res_moving_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]      out_speed_reg, out_speed_next;
    logic [31:0]             out_len_reg, out_len_next;
    logic                    out_moving_reg, out_moving_next;

    logic [GAP_W-1:0] gap_mem [WINDOW_DEPTH];

    logic [TIME_W-1:0] elapsed;
    logic              accept;
    logic              act;
    logic [GAP_W-1:0]  gap_in;
    logic [GAP_W-1:0]  old_gap;
    logic [SUM_W-1:0]  sum_upd;
    logic [GAP_W-1:0]  mean;
    logic              mem_we;

    logic               div_start;
    logic [SPEED_W-1:0] div_num;
    logic [GAP_W-1:0]   div_den;
    logic               div_done;
    logic [SPEED_W-1:0] div_quo;

    pps_div #(
        .NUM_W (SPEED_W),
        .DEN_W (GAP_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_speed_reg};
    assign m_tuser  = out_moving_reg;

    always_comb begin
        elapsed = s_tdata - last_time_reg;
        accept  = s_tvalid & s_tready;
        if (s_tuser == OP_PULSE) begin
            act    = (elapsed != '0);
            gap_in = (elapsed > TIME_W'(STOP_MARKER)) ? STOP_MARKER : elapsed[GAP_W-1:0];
        end else begin
            act    = moving_reg && (elapsed > timeout_reg);
            gap_in = STOP_MARKER;
        end
        old_gap = rd_valid_reg ? rd_data_reg : STOP_MARKER;
        sum_upd = sum_reg - SUM_W'(old_gap) + SUM_W'(gap_reg);
        mean    = sum_reg[SUM_W-1:PTR_W];

        state_next      = state_reg;
        timeout_next    = timeout_reg;
        numer_next      = numer_reg;
        corr_next       = corr_reg;
        sum_next        = sum_reg;
        pos_next        = pos_reg;
        last_time_next  = last_time_reg;
        tick_next       = tick_reg;
        moving_next     = moving_reg;
        valid_next      = valid_reg;
        rd_valid_next   = rd_valid_reg;
        gap_next        = gap_reg;
        prod_next       = prod_reg;
        len_next        = len_reg;
        speed_next      = speed_reg;
        res_moving_next = res_moving_reg;
        out_valid_next  = out_valid_reg;
        out_speed_next  = out_speed_reg;
        out_len_next    = out_len_reg;
        out_moving_next = out_moving_reg;
        mem_we          = 1'b0;
        div_start       = 1'b0;
        div_num         = numer_reg;
        div_den         = mean;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_STOP_TIMEOUT: timeout_next = cfg_wdata;
                REG_SPEED_NUMER:  numer_next   = cfg_wdata[SPEED_W-1:0];
                REG_LENGTH_CORR:  corr_next    = cfg_wdata[CORR_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && act) begin
                    gap_next      = gap_in;
                    rd_valid_next = valid_reg[pos_reg];
                    state_next    = ST_UPD;
                    if (s_tuser == OP_PULSE) begin
                        tick_next      = tick_reg + 32'd1;
                        last_time_next = s_tdata;
                    end
                end
            end
            ST_UPD: begin
                sum_next            = sum_upd;
                mem_we              = 1'b1;
                valid_next[pos_reg] = 1'b1;
                pos_next            = (pos_reg == PTR_LAST) ? '0 : pos_reg + PTR_W'(1);
                prod_next           = {9'd0, tick_reg[31:9]} * {23'd0, corr_reg};
                state_next          = ST_DIVM;
            end
            ST_DIVM: begin
                len_next = tick_reg - prod_reg;
                if (mean == STOP_MARKER || mean == '0) begin
                    speed_next      = '0;
                    res_moving_next = 1'b0;
                    state_next      = ST_EMIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS: begin
                if (div_done) begin
                    speed_next      = div_quo;
                    res_moving_next = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_speed_next  = speed_reg;
                    out_len_next    = len_reg;
                    out_moving_next = res_moving_reg;
                    moving_next     = res_moving_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            gap_mem[pos_reg] <= gap_reg;
        end
        if (accept) begin
            rd_data_reg <= gap_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= TIMEOUT_RESET;
            numer_reg     <= NUMER_RESET;
            corr_reg      <= CORR_RESET;
            sum_reg       <= SUM_RESET;
            pos_reg       <= '0;
            last_time_reg <= '0;
            tick_reg      <= '0;
            moving_reg    <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            timeout_reg   <= timeout_next;
            numer_reg     <= numer_next;
            corr_reg      <= corr_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            last_time_reg <= last_time_next;
            tick_reg      <= tick_next;
            moving_reg    <= moving_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
        rd_valid_reg   <= rd_valid_next;
        gap_reg        <= gap_next;
        prod_reg       <= prod_next;
        len_reg        <= len_next;
        speed_reg      <= speed_next;
        res_moving_reg <= res_moving_next;
        out_speed_reg  <= out_speed_next;
        out_len_reg    <= out_len_next;
        out_moving_reg <= out_moving_next;
    end

endmodule

`default_nettype wire

### rtl/core/pps_chk.sv
// port-level checks for the pulse period speed meter, bound to the top level
// depends on pulse_period_speed_meter_assert.svh
`default_nettype none

`include "pulse_period_speed_meter_assert.svh"

module pps_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tuser
);

    // stalled result word holds
    `PPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // stopped means zero speed
    `PPS_ASSERT_NOW(a_stop_speed, m_tvalid && !m_tuser, m_tdata[23:0] == 24'd0, "nonzero speed while stopped")

    // no result right after an input word is taken
    `PPS_ASSERT_NEXT(a_no_instant, s_tvalid && s_tready, !$rose(m_tvalid), "result appeared one cycle after input word")

    // a new result comes only out of a busy phase
    `PPS_ASSERT_NOW(a_from_busy, $rose(m_tvalid), $past(!s_tready), "result appeared without processing")

endmodule

bind pulse_period_speed_meter pps_chk u_pps_chk (.*);

`default_nettype wire
